FILE: hw/rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, constants and register map of the routing parent selector.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int unsigned MAX_CANDIDATES = 16;
  localparam int unsigned ETX_DIVISOR    = 128;

  localparam int unsigned POS_W   = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned ETX_W   = 16;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned ERP_W   = 8;

  localparam int unsigned ERP_SCALE = 100;
  localparam int unsigned DIVIDEND  = ETX_DIVISOR * ERP_SCALE;
  localparam int unsigned DIV_W     = $clog2(DIVIDEND + 1);
  localparam int unsigned DIV_STEPS = (DIV_W + 1) / 2;
  localparam int unsigned QUO_W     = 2 * DIV_STEPS;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [7:0]  RSSI_DEFAULT = 8'd50;
  localparam logic [15:0] SAT16        = 16'hffff;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = $clog2(NUM_REGS * 4);
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [2:0] {
    REG_ETX_WEIGHT     = 3'd0,
    REG_QUALITY_WEIGHT = 3'd1,
    REG_FIXED_HYST     = 3'd2,
    REG_MOBILE_HYST    = 3'd3,
    REG_SELF_FIXED     = 3'd4,
    REG_MOBILITY_PEN   = 3'd5,
    REG_LINK_LIMIT     = 3'd6,
    REG_PATH_LIMIT     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [3:0]  etx_weight;
    logic [3:0]  quality_weight;
    logic [15:0] fixed_node_hysteresis;
    logic [15:0] mobile_node_hysteresis;
    logic        self_is_fixed;
    logic [15:0] mobility_penalty;
    logic [15:0] link_limit;
    logic [15:0] path_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] link_etx;
    logic [15:0] base_cost;
    logic [7:0]  advertised_erp;
    logic [7:0]  rssi_magnitude;
    logic        rssi_known;
    logic        cand_fixed;
    logic        cand_preferred;
    logic        last_candidate;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  winner_index;
    logic [15:0] winner_score;
    logic [7:0]  winner_erp;
    logic        winner_preferred;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [ETX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_SCORE = 5'b01000,
    S_FOLD  = 5'b10000
  } state_e;

endpackage

FILE: hw/rtl/rps_cfg.sv
// ----------------------------------------------------------------------------
// rps_cfg
// APB-style register file holding the selector configuration.
// ----------------------------------------------------------------------------
module rps_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rps_pkg::ADDR_W-1:0] paddr,
  input  logic [rps_pkg::DATA_W-1:0] pwdata,
  output logic [rps_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rps_pkg::cfg_t              cfg_o
);
  import rps_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ETX_WEIGHT:     cfg_d.etx_weight             = pwdata[3:0];
        REG_QUALITY_WEIGHT: cfg_d.quality_weight         = pwdata[3:0];
        REG_FIXED_HYST:     cfg_d.fixed_node_hysteresis  = pwdata[15:0];
        REG_MOBILE_HYST:    cfg_d.mobile_node_hysteresis = pwdata[15:0];
        REG_SELF_FIXED:     cfg_d.self_is_fixed          = pwdata[0];
        REG_MOBILITY_PEN:   cfg_d.mobility_penalty       = pwdata[15:0];
        REG_LINK_LIMIT:     cfg_d.link_limit             = pwdata[15:0];
        REG_PATH_LIMIT:     cfg_d.path_limit             = pwdata[15:0];
        default:            cfg_d                        = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ETX_WEIGHT:     prdata = DATA_W'(cfg_q.etx_weight);
      REG_QUALITY_WEIGHT: prdata = DATA_W'(cfg_q.quality_weight);
      REG_FIXED_HYST:     prdata = DATA_W'(cfg_q.fixed_node_hysteresis);
      REG_MOBILE_HYST:    prdata = DATA_W'(cfg_q.mobile_node_hysteresis);
      REG_SELF_FIXED:     prdata = DATA_W'(cfg_q.self_is_fixed);
      REG_MOBILITY_PEN:   prdata = DATA_W'(cfg_q.mobility_penalty);
      REG_LINK_LIMIT:     prdata = DATA_W'(cfg_q.link_limit);
      REG_PATH_LIMIT:     prdata = DATA_W'(cfg_q.path_limit);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.etx_weight             <= 4'd4;
      cfg_q.quality_weight         <= 4'd2;
      cfg_q.fixed_node_hysteresis  <= 16'd300;
      cfg_q.mobile_node_hysteresis <= 16'd100;
      cfg_q.self_is_fixed          <= 1'b1;
      cfg_q.mobility_penalty       <= 16'd500;
      cfg_q.link_limit             <= 16'd1024;
      cfg_q.path_limit             <= 16'd32768;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/rps_div.sv
// ----------------------------------------------------------------------------
// rps_div
// Iterative restoring divider, two quotient bits per cycle, for the
// constant dividend ETX_DIVISOR * 100 over the link ETX.
// ----------------------------------------------------------------------------
module rps_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rps_pkg::div_req_t req_i,
  output rps_pkg::div_rsp_t rsp_o
);
  import rps_pkg::*;

  logic [ETX_W:0]    rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [ETX_W-1:0]  dvs_q;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    logic [ETX_W:0]   r;
    logic [QUO_W-1:0] q;
    r      = rem_q;
    q      = quo_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (busy_q) begin
      for (int i = 0; i < 2; i++) begin
        r = {r[ETX_W-1:0], q[QUO_W-1]};
        q = {q[QUO_W-2:0], 1'b0};
        if (r >= {1'b0, dvs_q}) begin
          r    = r - {1'b0, dvs_q};
          q[0] = 1'b1;
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    rem_d = r;
    quo_d = q;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = QUO_W'(DIVIDEND);
      cnt_d  = DCNT_W'(DIV_STEPS);
      busy_d = 1'b1;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[DIV_W-1:0];

endmodule

FILE: hw/rtl/routing_parent_selector.sv
// ----------------------------------------------------------------------------
// routing_parent_selector
// Folds routing-parent candidates into a running best and reports the
// winner on the last candidate of a scan.
//
//   channel  dir  handshake                        payload
//   in       in   in_valid_i / in_stall_o          in_data_i  (in_word_t)
//   out      out  out_valid_o / out_stall_i        out_data_o (out_word_t)
//   cfg      in   psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// A candidate goes through check, divide, score and fold; zero ETX skips
// the 12800/ETX division, and a rejected one or one beyond the table goes
// from check straight to fold. in_stall_o is high while a candidate is in
// work. The result word sits in an output register; a last candidate
// waits in the fold step while the previous result is still stalled.
// Reset clears the scan and the output valid and loads the cfg defaults.
// ----------------------------------------------------------------------------
module routing_parent_selector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rps_pkg::in_word_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rps_pkg::out_word_t         out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rps_pkg::ADDR_W-1:0] paddr,
  input  logic [rps_pkg::DATA_W-1:0] pwdata,
  output logic [rps_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rps_pkg::*;

  cfg_t      cfg;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  state_e    state_q, state_d;
  in_word_t  item_q;
  logic      ok_q, ok_d;
  logic [ERP_W-1:0]   erp_q, erp_d;
  logic [SCORE_W-1:0] score_q;

  logic               best_valid_q, best_valid_d;
  logic [POS_W-1:0]   best_pos_q, best_pos_d;
  logic [SCORE_W-1:0] best_score_q, best_score_d;
  logic [ERP_W-1:0]   best_erp_q, best_erp_d;
  logic               best_pref_q, best_pref_d;
  logic [POS_W-1:0]   pos_q, pos_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic               accept;
  logic               in_range;
  logic [ETX_W:0]     cost;
  logic               acceptable;
  logic [DIV_W-1:0]   rel;
  logic [ERP_W-1:0]   etx_erp;
  logic [ERP_W-1:0]   div_erp;
  logic [7:0]         rssi;
  logic [19:0]        etx_term;
  logic [12:0]        qual_term;
  logic [20:0]        score_sum;
  logic [SCORE_W-1:0] score_d;
  logic [SCORE_W-1:0] thr;
  logic signed [17:0] diff;
  logic               in_band;
  logic               take;
  logic               fold_go;

  rps_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  rps_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  assign in_range   = (pos_q < POS_W'(MAX_CANDIDATES));
  assign cost       = {1'b0, item_q.base_cost} + {1'b0, item_q.link_etx};
  assign acceptable = in_range && (item_q.link_etx <= cfg.link_limit) &&
                      ((cost[ETX_W] ? SAT16 : cost[ETX_W-1:0]) <= cfg.path_limit);

  assign div_req.start   = (state_q == S_CHECK) && acceptable && (item_q.link_etx != '0);
  assign div_req.divisor = item_q.link_etx;

  assign rel       = (div_rsp.quotient > DIV_W'(ERP_SCALE)) ? DIV_W'(ERP_SCALE)
                                                             : div_rsp.quotient;
  assign etx_erp   = ERP_W'(ERP_SCALE) - ERP_W'(rel);
  assign div_erp   = (item_q.advertised_erp > etx_erp) ? item_q.advertised_erp
                                                       : etx_erp;

  assign rssi      = item_q.rssi_known ? item_q.rssi_magnitude : RSSI_DEFAULT;
  assign etx_term  = 20'(cfg.etx_weight) * 20'(item_q.link_etx);
  assign qual_term = 13'(cfg.quality_weight) * (13'(erp_q) + 13'(rssi));
  assign score_sum = 21'(etx_term) + 21'(qual_term) +
                     (item_q.cand_fixed ? 21'd0 : 21'(cfg.mobility_penalty));
  assign score_d   = (score_sum > 21'(SAT16)) ? SAT16 : score_sum[SCORE_W-1:0];

  assign thr     = cfg.self_is_fixed ? cfg.fixed_node_hysteresis
                                     : cfg.mobile_node_hysteresis;
  assign diff    = signed'({2'b00, best_score_q}) - signed'({2'b00, score_q});
  assign in_band = (diff < signed'({2'b00, thr})) && (-diff < signed'({2'b00, thr}));

  always_comb begin
    priority if (!best_valid_q) begin
      take = 1'b1;
    end else if ((best_pref_q || item_q.cand_preferred) && in_band) begin
      take = !best_pref_q;
    end else begin
      take = !(best_score_q < score_q);
    end
  end

  assign fold_go = !item_q.last_candidate || !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    ok_d         = ok_q;
    erp_d        = erp_q;
    best_valid_d = best_valid_q;
    best_pos_d   = best_pos_q;
    best_score_d = best_score_q;
    best_erp_d   = best_erp_q;
    best_pref_d  = best_pref_q;
    pos_d        = pos_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CHECK;
      end
      S_CHECK: begin
        ok_d = acceptable;
        if (!acceptable) begin
          state_d = S_FOLD;
        end else if (item_q.link_etx == '0) begin
          erp_d   = (item_q.advertised_erp > ERP_W'(ERP_SCALE)) ?
                    item_q.advertised_erp : ERP_W'(ERP_SCALE);
          state_d = S_SCORE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          erp_d   = div_erp;
          state_d = S_SCORE;
        end
      end
      S_SCORE: begin
        state_d = S_FOLD;
      end
      S_FOLD: begin
        if (fold_go) begin
          if (ok_q && take) begin
            best_valid_d = 1'b1;
            best_pos_d   = pos_q;
            best_score_d = score_q;
            best_erp_d   = erp_q;
            best_pref_d  = item_q.cand_preferred;
          end
          if (in_range) pos_d = pos_q + 1'b1;
          if (item_q.last_candidate) begin
            out_valid_d = 1'b1;
            if (best_valid_d) begin
              out_d.found            = 1'b1;
              out_d.winner_index     = INDEX_W'(best_pos_d);
              out_d.winner_score     = best_score_d;
              out_d.winner_erp       = best_erp_d;
              out_d.winner_preferred = best_pref_d;
            end else begin
              out_d = '0;
            end
            best_valid_d = 1'b0;
            best_pos_d   = '0;
            best_score_d = '0;
            best_erp_d   = '0;
            best_pref_d  = 1'b0;
            pos_d        = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ok_q         <= 1'b0;
      best_valid_q <= 1'b0;
      best_pos_q   <= '0;
      best_score_q <= '0;
      best_erp_q   <= '0;
      best_pref_q  <= 1'b0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ok_q         <= ok_d;
      best_valid_q <= best_valid_d;
      best_pos_q   <= best_pos_d;
      best_score_q <= best_score_d;
      best_erp_q   <= best_erp_d;
      best_pref_q  <= best_pref_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == S_SCORE) score_q <= score_d;
    erp_q <= erp_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: dv/tb_routing_parent_selector.sv
// ----------------------------------------------------------------------------
// tb_routing_parent_selector
// Drives scans of routing-parent candidates through the selector and checks
// every winner word against a cycle-free model of the fold. The model tracks
// the running best, the hysteresis rules and the register settings. Stimulus
// is a short directed set of corner scans, then random scans under several
// register settings, with random idling on both channels and one long
// output hold-off.
// ----------------------------------------------------------------------------

class winner_board;
  rps_pkg::cfg_t      cfg;
  bit                 held;
  bit                 held_pref;
  int unsigned        held_pos;
  int unsigned        held_score;
  int unsigned        held_erp;
  int unsigned        scan_pos;
  rps_pkg::out_word_t winners_due[$];
  int unsigned        mismatches;
  int unsigned        winners_seen;

  function new();
    cfg = '{4'd4, 4'd2, 16'd300, 16'd100, 1'b1, 16'd500, 16'd1024, 16'd32768};
    mismatches   = 0;
    winners_seen = 0;
    restart_scan();
  endfunction

  function void restart_scan();
    held       = 1'b0;
    held_pref  = 1'b0;
    held_pos   = 0;
    held_score = 0;
    held_erp   = 0;
    scan_pos   = 0;
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", what);
  endfunction

  function void set_reg(rps_pkg::reg_idx_e idx, logic [31:0] v);
    case (idx)
      rps_pkg::REG_ETX_WEIGHT:     cfg.etx_weight             = v[3:0];
      rps_pkg::REG_QUALITY_WEIGHT: cfg.quality_weight         = v[3:0];
      rps_pkg::REG_FIXED_HYST:     cfg.fixed_node_hysteresis  = v[15:0];
      rps_pkg::REG_MOBILE_HYST:    cfg.mobile_node_hysteresis = v[15:0];
      rps_pkg::REG_SELF_FIXED:     cfg.self_is_fixed          = v[0];
      rps_pkg::REG_MOBILITY_PEN:   cfg.mobility_penalty       = v[15:0];
      rps_pkg::REG_LINK_LIMIT:     cfg.link_limit             = v[15:0];
      rps_pkg::REG_PATH_LIMIT:     cfg.path_limit             = v[15:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(rps_pkg::reg_idx_e idx);
    case (idx)
      rps_pkg::REG_ETX_WEIGHT:     return 32'(cfg.etx_weight);
      rps_pkg::REG_QUALITY_WEIGHT: return 32'(cfg.quality_weight);
      rps_pkg::REG_FIXED_HYST:     return 32'(cfg.fixed_node_hysteresis);
      rps_pkg::REG_MOBILE_HYST:    return 32'(cfg.mobile_node_hysteresis);
      rps_pkg::REG_SELF_FIXED:     return 32'(cfg.self_is_fixed);
      rps_pkg::REG_MOBILITY_PEN:   return 32'(cfg.mobility_penalty);
      rps_pkg::REG_LINK_LIMIT:     return 32'(cfg.link_limit);
      rps_pkg::REG_PATH_LIMIT:     return 32'(cfg.path_limit);
      default:                     return 32'd0;
    endcase
  endfunction

  // fold one accepted candidate into the running best; queue the winner at scan end
  function void note_candidate(rps_pkg::in_word_t w);
    int unsigned        cost;
    int unsigned        erp;
    int unsigned        rel;
    int unsigned        rssi;
    int unsigned        score;
    int                 thr;
    int                 b;
    int                 c;
    bit                 take;
    rps_pkg::out_word_t win;
    if (scan_pos < rps_pkg::MAX_CANDIDATES) begin
      cost = 32'(w.base_cost) + 32'(w.link_etx);
      if (cost > 32'(rps_pkg::SAT16)) cost = 32'(rps_pkg::SAT16);
      if (w.link_etx <= cfg.link_limit && cost <= 32'(cfg.path_limit)) begin
        erp = rps_pkg::ERP_SCALE;
        if (w.link_etx != 16'd0) begin
          rel = rps_pkg::DIVIDEND / 32'(w.link_etx);
          if (rel > rps_pkg::ERP_SCALE) rel = rps_pkg::ERP_SCALE;
          erp = rps_pkg::ERP_SCALE - rel;
        end
        if (32'(w.advertised_erp) > erp) erp = 32'(w.advertised_erp);
        rssi  = w.rssi_known ? 32'(w.rssi_magnitude) : 32'(rps_pkg::RSSI_DEFAULT);
        score = 32'(cfg.etx_weight) * 32'(w.link_etx)
              + 32'(cfg.quality_weight) * (erp + rssi);
        if (!w.cand_fixed) score += 32'(cfg.mobility_penalty);
        if (score > 32'(rps_pkg::SAT16)) score = 32'(rps_pkg::SAT16);
        if (!held) begin
          take = 1'b1;
        end else begin
          thr = cfg.self_is_fixed ? int'(cfg.fixed_node_hysteresis)
                                  : int'(cfg.mobile_node_hysteresis);
          b = int'(held_score);
          c = int'(score);
          if ((held_pref || w.cand_preferred) && b < c + thr && b > c - thr)
            take = !held_pref;
          else
            take = !(b < c);
        end
        if (take) begin
          held       = 1'b1;
          held_pos   = scan_pos;
          held_score = score;
          held_erp   = erp;
          held_pref  = w.cand_preferred;
        end
      end
      scan_pos++;
    end
    if (w.last_candidate) begin
      win = '0;
      if (held) begin
        win.found            = 1'b1;
        win.winner_index     = held_pos[3:0];
        win.winner_score     = held_score[15:0];
        win.winner_erp       = held_erp[7:0];
        win.winner_preferred = held_pref;
      end
      winners_due.push_back(win);
      restart_scan();
    end
  endfunction

  function void check_winner(rps_pkg::out_word_t got);
    rps_pkg::out_word_t want;
    winners_seen++;
    if (winners_due.size() == 0) begin
      report($sformatf("winner word %0d arrived with nothing expected", winners_seen));
      return;
    end
    want = winners_due.pop_front();
    if (got.found !== want.found || got.winner_index !== want.winner_index ||
        got.winner_score !== want.winner_score || got.winner_erp !== want.winner_erp ||
        got.winner_preferred !== want.winner_preferred)
      report($sformatf({"winner %0d: got found=%0b idx=%0d score=%0d erp=%0d pref=%0b,",
                        " expected found=%0b idx=%0d score=%0d erp=%0d pref=%0b"},
                       winners_seen, got.found, got.winner_index, got.winner_score,
                       got.winner_erp, got.winner_preferred, want.found,
                       want.winner_index, want.winner_score, want.winner_erp,
                       want.winner_preferred));
  endfunction

  function void close_out();
    if (winners_due.size() != 0) begin
      mismatches += winners_due.size();
      $display("MISMATCH: %0d expected winner words never arrived", winners_due.size());
    end
  endfunction
endclass

module tb_routing_parent_selector;
  import rps_pkg::*;

  logic                clk;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  winner_board sb;
  bit          idle_on;
  bit          hold_req;
  int          hold_left;
  int unsigned items_sent;
  int unsigned scans_sent;
  int unsigned settings_used;

  routing_parent_selector uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("** routing_parent_selector: FAILED **");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int burst;
    burst     = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_winner(out_data);
      if (in_valid === 1'b1 && in_stall === 1'b0) sb.note_candidate(in_data);
    end
  end

  task automatic rest_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_word(input in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) rest_input($urandom_range(1, 13));
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (w.last_candidate) scans_sent++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(idx, val);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== sb.reg_value(idx))
      sb.report($sformatf("register %s read %0h, expected %0h", idx.name(), prdata,
                          sb.reg_value(idx)));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_ETX_WEIGHT, 32'(c.etx_weight));
    write_reg(REG_QUALITY_WEIGHT, 32'(c.quality_weight));
    write_reg(REG_FIXED_HYST, 32'(c.fixed_node_hysteresis));
    write_reg(REG_MOBILE_HYST, 32'(c.mobile_node_hysteresis));
    write_reg(REG_SELF_FIXED, 32'(c.self_is_fixed));
    write_reg(REG_MOBILITY_PEN, 32'(c.mobility_penalty));
    write_reg(REG_LINK_LIMIT, 32'(c.link_limit));
    write_reg(REG_PATH_LIMIT, 32'(c.path_limit));
    settings_used++;
  endtask

  // drain results, then cover a candidate still in work
  task automatic settle();
    rest_input(1);
    while (sb.winners_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.etx_weight             = 4'($urandom_range(0, 15));
    c.quality_weight         = 4'($urandom_range(0, 15));
    c.fixed_node_hysteresis  = 16'($urandom_range(0, 1500));
    c.mobile_node_hysteresis = 16'($urandom_range(0, 65535));
    c.self_is_fixed          = 1'($urandom_range(0, 1));
    c.mobility_penalty       = 16'($urandom_range(0, 65535));
    c.link_limit             = 16'($urandom_range(0, 65535));
    c.path_limit             = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  function automatic in_word_t cand(input logic [15:0] etx, input logic [15:0] base,
                                    input logic [7:0] adv, input logic [7:0] rssi,
                                    input logic known, input logic fixed,
                                    input logic pref, input logic last);
    in_word_t w;
    w.link_etx       = etx;
    w.base_cost      = base;
    w.advertised_erp = adv;
    w.rssi_magnitude = rssi;
    w.rssi_known     = known;
    w.cand_fixed     = fixed;
    w.cand_preferred = pref;
    w.last_candidate = last;
    return w;
  endfunction

  function automatic in_word_t random_candidate(input logic last);
    in_word_t w;
    case ($urandom_range(0, 7))
      0:       w.link_etx = 16'd0;
      1:       w.link_etx = 16'hffff;
      2:       w.link_etx = 16'($urandom_range(1, 128));
      3:       w.link_etx = 16'($urandom_range(129, 1500));
      4, 5:    w.link_etx = 16'($urandom_range(0, sb.cfg.link_limit));
      default: w.link_etx = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       w.base_cost = 16'd0;
      1:       w.base_cost = 16'hffff;
      2, 3:    w.base_cost = 16'($urandom_range(0, 65535));
      default: w.base_cost = 16'($urandom_range(0, sb.cfg.path_limit));
    endcase
    w.advertised_erp = 8'($urandom_range(0, 255));
    w.rssi_magnitude = 8'($urandom_range(0, 128));
    w.rssi_known     = 1'($urandom_range(0, 1));
    w.cand_fixed     = 1'($urandom_range(0, 1));
    w.cand_preferred = ($urandom_range(0, 3) == 0);
    w.last_candidate = last;
    return w;
  endfunction

  task automatic run_scans(input int target);
    int done_items;
    int len;
    int i;
    done_items = 0;
    while (done_items < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (i = 0; i < len; i++) send_word(random_candidate(i == len - 1));
      done_items += len;
    end
  endtask

  initial begin
    int   i;
    int   waited;
    cfg_t c;
    sb            = new();
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    items_sent    = 0;
    scans_sent    = 0;
    settings_used = 0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;

    // directed scans under the reset settings
    send_word(cand(16'd0, 16'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1));
    send_word(cand(16'hffff, 16'd0, 8'd0, 8'd128, 1'b1, 1'b0, 1'b1, 1'b1));
    // preferred best survives a slightly better one; saturated path; limits
    send_word(cand(16'd128, 16'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0));
    send_word(cand(16'd1, 16'hffff, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(cand(16'd100, 16'd0, 8'd0, 8'd77, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(cand(16'd1024, 16'd31744, 8'd255, 8'd128, 1'b1, 1'b0, 1'b0, 1'b1));
    // equal scores go to the candidate
    send_word(cand(16'd256, 16'd5, 8'd0, 8'd10, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(cand(16'd256, 16'd9, 8'd0, 8'd10, 1'b1, 1'b1, 1'b0, 1'b1));
    // both preferred: keep the held one
    send_word(cand(16'd300, 16'd0, 8'd0, 8'd20, 1'b1, 1'b1, 1'b1, 1'b0));
    send_word(cand(16'd290, 16'd0, 8'd0, 8'd20, 1'b1, 1'b1, 1'b1, 1'b1));
    // preferred candidate inside the window replaces a better plain one
    send_word(cand(16'd100, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_word(cand(16'd128, 16'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    // overlong scan: the candidate past the table end is dropped
    for (i = 0; i < 16; i++)
      send_word(cand(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1000)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 128)),
                     1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0));
    send_word(cand(16'd0, 16'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1));

    settle();
    program_regs(random_cfg());
    run_scans(270);

    settle();
    program_regs('{4'hf, 4'hf, 16'hffff, 16'hffff, 1'b1, 16'hffff, 16'hffff, 16'hffff});
    run_scans(270);

    settle();
    program_regs('0);
    run_scans(200);

    settle();
    program_regs(random_cfg());
    hold_req = 1'b1;
    run_scans(270);

    settle();
    program_regs('{4'd4, 4'd2, 16'd300, 16'd100, 1'b0, 16'd500, 16'd1024, 16'd32768});
    run_scans(270);

    settle();
    idle_on = 1'b0;
    program_regs(random_cfg());
    run_scans(270);

    rest_input(1);
    waited = 0;
    while (sb.winners_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    sb.close_out();

    $display("Run covered %0d candidates in %0d scans under %0d register settings,",
             items_sent, scans_sent, settings_used + 1);
    $display("with %0d winner words checked, random idling and one long output hold-off.",
             sb.winners_seen);
    if (sb.mismatches == 0)
      $display("** routing_parent_selector: PASSED **");
    else
      $display("** routing_parent_selector: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rps_pkg.sv
hw/rtl/rps_cfg.sv
hw/rtl/rps_div.sv
hw/rtl/routing_parent_selector.sv
dv/tb_routing_parent_selector.sv
